// ----- sv/io_register_block_with_timer_top_assert.svh -----
// ----------------------------------------------------------------------------
// io_register_block_with_timer_top_assert.svh
// Assertion macros for the I/O register block. Each macro expects clk and
// rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef IO_REGISTER_BLOCK_WITH_TIMER_TOP_ASSERT_SVH
`define IO_REGISTER_BLOCK_WITH_TIMER_TOP_ASSERT_SVH

// Antecedent in one cycle implies the consequent in the next cycle
`define IORBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Antecedent implies the consequent in the same cycle
`define IORBT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`endif

// ----- sv/iorbt_pkg.sv -----
// ----------------------------------------------------------------------------
// iorbt_pkg
// Shared types, address map, constants and tables of the I/O register block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iorbt_pkg;

    // Sizing
    localparam int CPU_CLOCK_HZ = 32768;
    localparam int STORE_DEPTH  = 128;   // power of two, 128..256
    localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
    localparam int IRQ_SOURCES  = 6;
    localparam int IRQ_IDX_W    = $clog2(IRQ_SOURCES);
    localparam int ADDR_W       = 12;
    localparam int DATA_W       = 4;
    localparam int KEYS_W       = 3;
    localparam int CNT_W        = 9;
    localparam int RLD_W        = 8;
    localparam int PER_W        = 16;
    localparam int OP_W         = 2;

    // Bus operations
    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RAISE = 2'd2
    } op_t;

    // Address map
    localparam logic [ADDR_W-1:0] ADDR_FAC_FIRST = 12'hF00;
    localparam logic [ADDR_W-1:0] ADDR_FAC_LAST  = ADDR_FAC_FIRST + ADDR_W'(IRQ_SOURCES - 1);
    localparam logic [ADDR_W-1:0] ADDR_MSK_FIRST = 12'hF10;
    localparam logic [ADDR_W-1:0] ADDR_MSK_LAST  = ADDR_MSK_FIRST + ADDR_W'(IRQ_SOURCES - 1);
    localparam logic [ADDR_W-1:0] ADDR_CNT_LO    = 12'hF24;
    localparam logic [ADDR_W-1:0] ADDR_CNT_HI    = 12'hF25;
    localparam logic [ADDR_W-1:0] ADDR_RLD_LO    = 12'hF26;
    localparam logic [ADDR_W-1:0] ADDR_RLD_HI    = 12'hF27;
    localparam logic [ADDR_W-1:0] ADDR_KEYS      = 12'hF40;
    localparam logic [ADDR_W-1:0] ADDR_VDET      = 12'hF73;
    localparam logic [ADDR_W-1:0] ADDR_TCTRL     = 12'hF78;
    localparam logic [ADDR_W-1:0] ADDR_TCLK      = 12'hF79;

    // Register bit fields and fixed values
    localparam int                TCTRL_RUN_BIT  = 0;
    localparam int                TCTRL_LOAD_BIT = 1;
    localparam int                VDET_OK_BIT    = 2;
    localparam logic [DATA_W-1:0] VDET_OK        = 4'b0110;
    localparam logic [DATA_W-1:0] KEYS_FIXED     = 4'b1000;
    localparam logic [2:0]        LOW3_MASK      = 3'b111;
    localparam logic [CNT_W-1:0]  CNT_FULL       = 9'd256;

    // Timer clock select: codes below the minimum leave the period alone
    localparam int               CLK_SEL_CODES = 6;
    localparam logic [2:0]       CLK_SEL_MIN   = 3'd2;

    function automatic logic [PER_W-1:0] period_sat(input int raw);
        period_sat = (raw > 65535) ? 16'hFFFF : raw[PER_W-1:0];
    endfunction

    localparam logic [PER_W-1:0] PERIOD_TAB [CLK_SEL_CODES] = '{
        period_sat(CPU_CLOCK_HZ / 256),
        period_sat(CPU_CLOCK_HZ / 512),
        period_sat(CPU_CLOCK_HZ / 1024),
        period_sat(CPU_CLOCK_HZ / 2048),
        period_sat(CPU_CLOCK_HZ / 4096),
        period_sat(CPU_CLOCK_HZ / 8192)
    };

    // Store entries with a nonzero value out of reset
    localparam logic [STORE_IDX_W-1:0] RST_KEYS_IDX = STORE_IDX_W'(12'h040 % STORE_DEPTH);
    localparam logic [STORE_IDX_W-1:0] RST_VDET_IDX = STORE_IDX_W'(12'h073 % STORE_DEPTH);
    localparam logic [DATA_W-1:0]      RST_KEYS_VAL = 4'hF;
    localparam logic [DATA_W-1:0]      RST_VDET_VAL = 4'h8;

    function automatic logic [DATA_W-1:0] store_reset_value(
        input logic [STORE_IDX_W-1:0] idx
    );
        if (idx == RST_KEYS_IDX)
            store_reset_value = RST_KEYS_VAL;
        else if (idx == RST_VDET_IDX)
            store_reset_value = RST_VDET_VAL;
        else
            store_reset_value = '0;
    endfunction

    // One bus transaction
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [KEYS_W-1:0] keys_down;
    } item_t;

    // Store write request from the core
    typedef struct packed {
        logic                   en;
        logic [STORE_IDX_W-1:0] idx;
        logic [DATA_W-1:0]      data;
    } store_wr_t;

endpackage

// ----- sv/iorbt_ram.sv -----
// ----------------------------------------------------------------------------
// iorbt_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iorbt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/iorbt_store.sv -----
// ----------------------------------------------------------------------------
// iorbt_store
// General nibble store: RAM, per-entry valid bits standing in for the reset
// contents, and a one-deep bypass for a write landing on the read edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iorbt_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [iorbt_pkg::STORE_IDX_W-1:0] rd_idx,
    input  logic [iorbt_pkg::STORE_IDX_W-1:0] cur_idx,
    input  iorbt_pkg::store_wr_t             wr,
    output logic [iorbt_pkg::DATA_W-1:0]     rd_data
);

    import iorbt_pkg::*;

    logic [DATA_W-1:0]      ram_q;
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [STORE_DEPTH-1:0] valid_next;
    logic                   byp_valid_reg;
    logic [STORE_IDX_W-1:0] byp_idx_reg;
    logic [DATA_W-1:0]      byp_data_reg;

    iorbt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.idx),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (ram_q)
    );

    // Entry becomes valid on its first write
    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            byp_valid_reg <= wr.en;
        end
    end

    // Bypass payload: the write that shares an edge with the current read
    always_ff @(posedge clk)
    begin
        byp_idx_reg  <= wr.idx;
        byp_data_reg <= wr.data;
    end

    // Stored nibble for the transaction in the core
    always_comb
    begin
        if (byp_valid_reg && (byp_idx_reg == cur_idx))
            rd_data = byp_data_reg;
        else if (valid_reg[cur_idx])
            rd_data = ram_q;
        else
            rd_data = store_reset_value(cur_idx);
    end

endmodule

// ----- sv/iorbt_core.sv -----
// ----------------------------------------------------------------------------
// iorbt_core
// Decode and update for one registered transaction: interrupt factors and
// masks, timer reload, counter, enable and period, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iorbt_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  iorbt_pkg::item_t             item,
    input  logic [iorbt_pkg::DATA_W-1:0] store_data,
    output iorbt_pkg::store_wr_t         store_wr,
    output logic                         done,
    output logic [iorbt_pkg::DATA_W-1:0] read_data,
    output logic                         timer_enabled,
    output logic [iorbt_pkg::CNT_W-1:0]  timer_counter,
    output logic [iorbt_pkg::RLD_W-1:0]  timer_reload,
    output logic [iorbt_pkg::PER_W-1:0]  timer_period,
    output logic                         timer_start
);

    import iorbt_pkg::*;

    logic [DATA_W-1:0] irq_factor_reg  [IRQ_SOURCES];
    logic [DATA_W-1:0] irq_factor_next [IRQ_SOURCES];
    logic [DATA_W-1:0] irq_mask_reg    [IRQ_SOURCES];
    logic [DATA_W-1:0] irq_mask_next   [IRQ_SOURCES];
    logic [CNT_W-1:0]  counter_reg;
    logic [CNT_W-1:0]  counter_next;
    logic [RLD_W-1:0]  reload_reg;
    logic [RLD_W-1:0]  reload_next;
    logic              on_reg;
    logic              on_next;
    logic [PER_W-1:0]  period_reg;
    logic [PER_W-1:0]  period_next;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;
    logic              start_reg;
    logic              start_next;
    logic              done_reg;

    logic [IRQ_IDX_W-1:0] src_idx;
    logic [DATA_W-1:0]    d;
    logic [2:0]           clk_sel;

    assign src_idx = item.address[IRQ_IDX_W-1:0];
    assign d       = item.write_data;
    assign clk_sel = d[2:0];

    // Transaction decode and next state
    always_comb
    begin
        irq_factor_next = irq_factor_reg;
        irq_mask_next   = irq_mask_reg;
        counter_next    = counter_reg;
        reload_next     = reload_reg;
        on_next         = on_reg;
        period_next     = period_reg;
        read_data_next  = '0;
        start_next      = 1'b0;
        store_wr.en     = 1'b0;
        store_wr.idx    = item.address[STORE_IDX_W-1:0];
        store_wr.data   = d;

        if (item_valid)
        begin
            case (item.op)
                OP_READ:
                begin
                    case (item.address) inside
                        [ADDR_FAC_FIRST:ADDR_FAC_LAST]:
                        begin
                            // clear on read
                            read_data_next           = irq_factor_reg[src_idx];
                            irq_factor_next[src_idx] = '0;
                        end
                        [ADDR_MSK_FIRST:ADDR_MSK_LAST]:
                            read_data_next = irq_mask_reg[src_idx];
                        ADDR_CNT_LO: read_data_next = counter_reg[3:0];
                        ADDR_CNT_HI: read_data_next = counter_reg[7:4];
                        ADDR_RLD_LO: read_data_next = reload_reg[3:0];
                        ADDR_RLD_HI: read_data_next = reload_reg[7:4];
                        ADDR_KEYS:   read_data_next = KEYS_FIXED | {1'b0, ~item.keys_down};
                        ADDR_VDET:
                            read_data_next = store_data[VDET_OK_BIT] ? VDET_OK : store_data;
                        ADDR_TCTRL:  read_data_next = {3'b000, on_reg};
                        default:     read_data_next = store_data;
                    endcase
                end
                OP_WRITE:
                begin
                    case (item.address) inside
                        [ADDR_FAC_FIRST:ADDR_FAC_LAST], ADDR_CNT_LO, ADDR_CNT_HI, ADDR_KEYS:
                        begin
                            // read-only
                        end
                        [ADDR_MSK_FIRST:ADDR_MSK_LAST]:
                            irq_mask_next[src_idx] = d;
                        ADDR_RLD_LO: reload_next = {reload_reg[7:4], d};
                        ADDR_RLD_HI: reload_next = {d, reload_reg[3:0]};
                        ADDR_VDET:
                        begin
                            store_wr.en   = 1'b1;
                            store_wr.data = {1'b0, d[2:0] & LOW3_MASK};
                        end
                        ADDR_TCTRL:
                        begin
                            // zero reload loads as a full count
                            if (d[TCTRL_LOAD_BIT])
                            begin
                                counter_next = (reload_reg == '0) ? CNT_FULL
                                                                  : {1'b0, reload_reg};
                            end
                            start_next  = !on_reg && d[TCTRL_RUN_BIT];
                            on_next     = d[TCTRL_RUN_BIT];
                            store_wr.en = 1'b1;
                        end
                        ADDR_TCLK:
                        begin
                            if (clk_sel >= CLK_SEL_MIN)
                            begin
                                period_next = PERIOD_TAB[clk_sel - CLK_SEL_MIN];
                            end
                            store_wr.en = 1'b1;
                        end
                        default: store_wr.en = 1'b1;
                    endcase
                end
                OP_RAISE:
                begin
                    // out-of-range source index is ignored
                    if (item.address < ADDR_W'(IRQ_SOURCES))
                    begin
                        irq_factor_next[src_idx] = irq_factor_reg[src_idx] | d;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < IRQ_SOURCES; i++)
            begin
                irq_factor_reg[i] <= '0;
                irq_mask_reg[i]   <= '0;
            end
            counter_reg <= '0;
            reload_reg  <= '0;
            on_reg      <= 1'b0;
            period_reg  <= '0;
            start_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            irq_factor_reg <= irq_factor_next;
            irq_mask_reg   <= irq_mask_next;
            counter_reg    <= counter_next;
            reload_reg     <= reload_next;
            on_reg         <= on_next;
            period_reg     <= period_next;
            start_reg      <= start_next;
            done_reg       <= item_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
    end

    assign done          = done_reg;
    assign read_data     = read_data_reg;
    assign timer_start   = start_reg;
    assign timer_enabled = on_reg;
    assign timer_counter = counter_reg;
    assign timer_reload  = reload_reg;
    assign timer_period  = period_reg;

endmodule

// ----- sv/io_register_block_with_timer_top.sv -----
// ----------------------------------------------------------------------------
// io_register_block_with_timer_top
// Nibble-wide I/O register block with timer front end.
//
// One bus transaction (read, write or interrupt-factor raise) is accepted on
// any clock edge with start high; busy never rises, so a transaction can be
// issued every cycle. Each transaction yields one result, strobed by done for
// exactly one cycle. The accepting edge loads the input register and the
// registered read of the general store RAM; the result register, which drives
// done and the result ports, is loaded from them. The receiver
// cannot stall results, so done and the result ports must be sampled in that
// cycle. Timer outputs show the state after the transaction. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module io_register_block_with_timer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [iorbt_pkg::OP_W-1:0]   op,
    input  logic [iorbt_pkg::ADDR_W-1:0] address,
    input  logic [iorbt_pkg::DATA_W-1:0] write_data,
    input  logic [iorbt_pkg::KEYS_W-1:0] keys_down,
    output logic                         done,
    output logic [iorbt_pkg::DATA_W-1:0] read_data,
    output logic                         timer_enabled,
    output logic [iorbt_pkg::CNT_W-1:0]  timer_counter,
    output logic [iorbt_pkg::RLD_W-1:0]  timer_reload,
    output logic [iorbt_pkg::PER_W-1:0]  timer_period,
    output logic                         timer_start
);

    import iorbt_pkg::*;

    `include "io_register_block_with_timer_top_assert.svh"

    logic              accept;
    logic              item_valid_reg;
    item_t             item_reg;
    logic [DATA_W-1:0] store_data;
    store_wr_t         store_wr;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op         <= op_t'(op);
            item_reg.address    <= address;
            item_reg.write_data <= write_data;
            item_reg.keys_down  <= keys_down;
        end
    end

    // General store, read on acceptance
    iorbt_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (address[STORE_IDX_W-1:0]),
        .cur_idx (item_reg.address[STORE_IDX_W-1:0]),
        .wr      (store_wr),
        .rd_data (store_data)
    );

    // Decode, state update and result register
    iorbt_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid_reg),
        .item          (item_reg),
        .store_data    (store_data),
        .store_wr      (store_wr),
        .done          (done),
        .read_data     (read_data),
        .timer_enabled (timer_enabled),
        .timer_counter (timer_counter),
        .timer_reload  (timer_reload),
        .timer_period  (timer_period),
        .timer_start   (timer_start)
    );

    // Assertions
    `IORBT_ASSERT_NEXT(a_accept_to_core, accept, item_valid_reg)
    `IORBT_ASSERT_NEXT(a_core_to_done, item_valid_reg, done)
    `IORBT_ASSERT_SAME(a_start_needs_done, timer_start, done)
    `IORBT_ASSERT_SAME(a_start_means_on, timer_start, timer_enabled)

endmodule
